[hw/rtl/page_frame_allocator_assert.svh]
// Assertion macros for the page frame allocator RTL.
// Included by pfa_back, which checks its own logic; needs no package.
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition holds in the cycle after the trigger
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pfa_pkg.sv]
// Shared types and constants of the page frame allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package pfa_pkg;

   // Sizes
   localparam int ADDR_W      = 32;
   localparam int CNT_W       = 21;
   localparam int DEPTH_W     = 9;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
   localparam int NEXT_W      = ((ADDR_W > CNT_W + PAGE_SHIFT) ? ADDR_W
                                 : CNT_W + PAGE_SHIFT) + 2;

   // Register map
   typedef logic [0:0] csr_idx_type;
   localparam csr_idx_type CSR_WINDOW_START = 1'b0;
   localparam csr_idx_type CSR_WINDOW_END   = 1'b1;

   typedef enum logic [0:0] {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOPAGE    = 3'd1,
      ST_NULL      = 3'd2,
      ST_UNALIGNED = 3'd3,
      ST_RANGE     = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] page_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  granted_addr;
      logic [CNT_W-1:0]   pages_in_use;
      logic [DEPTH_W-1:0] stack_depth;
   } rsp_type;

   // Queue entry: request plus the stateless free verdict
   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] page_addr;
      status_type        verdict;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_POP  = 2'd1,
      BK_BUMP = 2'd2
   } bk_state_type;

endpackage

`default_nettype wire

[hw/rtl/page_frame_allocator.sv]
// Page frame allocator: free-page stack first, then a bump pointer over the window.
// Frees, and allocates refused for an unset window or a full bump counter, finish in the
// back-end sequencer's idle state; other allocates pass through a second state (stack memory
// read, then the pop; or bump address add, then the end check). Results go through an output
// register that holds while stalled; a 2-word queue decouples input.
// Synchronous reset clears window registers, stack pointer and counters; no memory sweep.
`default_nettype none

module page_frame_allocator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pfa_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pfa_pkg::rsp_type            rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire pfa_pkg::csr_idx_type   csr_index,
   input  wire logic [pfa_pkg::ADDR_W-1:0] csr_wdata
);
   import pfa_pkg::*;

   logic [ADDR_W-1:0] window_start_ff, window_start_in;
   logic [ADDR_W-1:0] window_end_ff, window_end_in;
   logic              push, fifo_full, q_valid, q_pop;
   cmd_type           push_entry, q_entry;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      window_start_in = window_start_ff;
      window_end_in   = window_end_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_START: window_start_in = csr_wdata;
            CSR_WINDOW_END:   window_end_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         window_end_ff   <= '0;
      end else begin
         window_start_ff <= window_start_in;
         window_end_ff   <= window_end_in;
      end
   end

   pfa_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .window_start (window_start_ff),
      .window_end   (window_end_ff),
      .fifo_full    (fifo_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   pfa_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_entry)
   );

   pfa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .window_start (window_start_ff),
      .window_end   (window_end_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/pfa_front.sv]
// Front end: accepts request words and checks free addresses for null, alignment and the window.
// Depends on pfa_pkg; feeds pfa_fifo.
`default_nettype none

module pfa_front (
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire pfa_pkg::req_type          req_data,
   input  wire logic [pfa_pkg::ADDR_W-1:0] window_start,
   input  wire logic [pfa_pkg::ADDR_W-1:0] window_end,
   input  wire logic                      fifo_full,
   output logic                           push,
   output pfa_pkg::cmd_type               push_entry
);
   import pfa_pkg::*;

   status_type verdict;

   // Free checks in priority order: null, unaligned, outside window
   always_comb begin
      if (req_data.page_addr == '0) begin
         verdict = ST_NULL;
      end else if (req_data.page_addr[PAGE_SHIFT-1:0] != '0) begin
         verdict = ST_UNALIGNED;
      end else if (req_data.page_addr < window_start ||
                   req_data.page_addr >= window_end) begin
         verdict = ST_RANGE;
      end else begin
         verdict = ST_OK;
      end
   end

   assign req_stall            = fifo_full;
   assign push                 = req_valid & ~fifo_full;
   assign push_entry.func      = req_data.func;
   assign push_entry.page_addr = req_data.page_addr;
   assign push_entry.verdict   = (req_data.func == FUNC_FREE) ? verdict : ST_OK;

endmodule

`default_nettype wire

[hw/rtl/pfa_fifo.sv]
// Two-entry command queue between front end and back end.
// Depends on pfa_pkg for the entry type.
`default_nettype none

module pfa_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire pfa_pkg::cmd_type push_entry,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output pfa_pkg::cmd_type      head
);
   import pfa_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hw/rtl/pfa_back.sv]
// Back end: runs queued commands against the free-page stack and counters.
// Depends on pfa_pkg and page_frame_allocator_assert.svh.
`default_nettype none

`include "page_frame_allocator_assert.svh"

module pfa_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire pfa_pkg::cmd_type           q_entry,
   output logic                            q_pop,
   input  wire logic [pfa_pkg::ADDR_W-1:0] window_start,
   input  wire logic [pfa_pkg::ADDR_W-1:0] window_end,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pfa_pkg::rsp_type                rsp_data
);
   import pfa_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   bk_state_type        state_ff, state_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [CNT_W-1:0]    bump_ff, bump_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [NEXT_W-1:0]   next_ff, next_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ADDR_W-1:0]   stack_mem [STACK_DEPTH];
   logic [ADDR_W-1:0]   rdata_ff;
   logic                rd_en, wr_en;
   logic [TOP_W-1:0]    top_dec;
   logic [STACK_AW-1:0] rd_addr, wr_addr;

   logic                out_free, finish;
   status_type          res_status;
   logic [ADDR_W-1:0]   res_addr;
   logic [CNT_W-1:0]    used_up, used_down;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign top_dec   = top_ff - 1'b1;
   assign rd_addr   = top_dec[STACK_AW-1:0];
   assign wr_addr   = top_ff[STACK_AW-1:0];
   assign used_up   = (used_ff == CNT_MAX) ? used_ff : used_ff + 1'b1;
   assign used_down = (used_ff == '0) ? used_ff : used_ff - 1'b1;

   // Command sequencer
   always_comb begin
      state_in   = state_ff;
      top_in     = top_ff;
      bump_in    = bump_ff;
      used_in    = used_ff;
      next_in    = next_ff;
      q_pop      = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      finish     = 1'b0;
      res_status = ST_OK;
      res_addr   = '0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_entry.func == FUNC_FREE) begin
                  if (out_free) begin
                     finish = 1'b1;
                     q_pop  = 1'b1;
                     if (q_entry.verdict != ST_OK) begin
                        res_status = q_entry.verdict;
                     end else if (top_ff >= TOP_W'(STACK_DEPTH)) begin
                        res_status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        top_in  = top_ff + 1'b1;
                        used_in = used_down;
                     end
                  end
               end else if (top_ff != '0) begin
                  // Stack read, data lands next cycle
                  rd_en    = 1'b1;
                  state_in = BK_POP;
               end else if (window_start == '0 || bump_ff == CNT_MAX) begin
                  if (out_free) begin
                     finish     = 1'b1;
                     q_pop      = 1'b1;
                     res_status = ST_NOPAGE;
                  end
               end else begin
                  next_in  = NEXT_W'(window_start) + (NEXT_W'(bump_ff) << PAGE_SHIFT);
                  state_in = BK_BUMP;
               end
            end
         end
         BK_POP: begin
            if (out_free) begin
               finish   = 1'b1;
               q_pop    = 1'b1;
               res_addr = rdata_ff;
               top_in   = top_dec;
               used_in  = used_up;
               state_in = BK_IDLE;
            end
         end
         BK_BUMP: begin
            if (out_free) begin
               finish   = 1'b1;
               q_pop    = 1'b1;
               state_in = BK_IDLE;
               if ((next_ff + NEXT_W'(PAGE_BYTES)) > NEXT_W'(window_end)) begin
                  res_status = ST_NOPAGE;
               end else begin
                  res_addr = next_ff[ADDR_W-1:0];
                  bump_in  = bump_ff + 1'b1;
                  used_in  = used_up;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Output register: holds while stalled, loads on completion
   always_comb begin
      rsp_valid_in = (rsp_valid_ff & rsp_stall) | finish;
      rsp_in       = rsp_ff;
      if (finish) begin
         rsp_in.status       = res_status;
         rsp_in.granted_addr = res_addr;
         rsp_in.pages_in_use = used_in;
         rsp_in.stack_depth  = DEPTH_W'(top_in);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         top_ff       <= '0;
         bump_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         bump_ff      <= bump_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      next_ff <= next_in;
      rsp_ff  <= rsp_in;
   end

   // Free-page stack
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= q_entry.page_addr;
      end
      if (rd_en) begin
         rdata_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PFA_ASSERT_NOW(a_top_bound, clock, reset, 1'b1, top_ff <= TOP_W'(STACK_DEPTH), "stack pointer past depth")
   `PFA_ASSERT_NOW(a_pop_nonempty, clock, reset, state_ff == BK_POP, top_ff != '0, "pop from empty stack")
   `PFA_ASSERT_NOW(a_fail_no_addr, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK, rsp_ff.granted_addr == '0, "address granted on failure")
   `PFA_ASSERT_NEXT(a_bump_done, clock, reset, state_ff == BK_BUMP && out_free, state_ff == BK_IDLE && rsp_valid_ff, "bump allocate did not complete")

endmodule

`default_nettype wire

[tb/page_frame_allocator_test.sv]
// Self-checking testbench for the page frame allocator: drives page requests and
// window register writes, predicts every result word and checks it field by field.
// Needs pfa_pkg and page_frame_allocator.
`timescale 1ns / 1ps

module page_frame_allocator_test;
   import pfa_pkg::*;

   localparam int CNT_LIMIT   = (1 << CNT_W) - 1;
   localparam int LONG_HOLD   = 150;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 190;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_idx_type           csr_index = CSR_WINDOW_START;
   logic [ADDR_W-1:0]     csr_wdata = '0;

   // Predicted allocator state
   logic [ADDR_W-1:0]     win_start = '0;
   logic [ADDR_W-1:0]     win_end = '0;
   logic [ADDR_W-1:0]     freed_stack [STACK_DEPTH];
   int                    stack_fill = 0;
   int                    bump_count = 0;
   int                    in_use = 0;

   // Words waiting to go in, and results waiting to come out
   req_type               pending_words [$];
   rsp_type               expected_words [$];
   logic [ADDR_W-1:0]     granted_pool [$];

   bit                    sender_bursty = 1'b0;
   bit                    receiver_bursty = 1'b0;
   bit                    long_hold_req = 1'b0;
   bit                    drain_hold = 1'b0;
   int                    send_gap = 0;
   int                    recv_gap = 0;
   int                    hold_left = 0;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   page_frame_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Expected result of one accepted request; updates the predicted state
   function automatic rsp_type allocator_predict(req_type r);
      rsp_type           o;
      longint unsigned   next_addr;
      bit                granted;
      o = '0;
      o.status = ST_OK;
      granted = 1'b0;
      if (r.func == FUNC_ALLOC) begin
         if (stack_fill > 0) begin
            stack_fill--;
            o.granted_addr = freed_stack[stack_fill];
            granted = 1'b1;
         end else if (win_start == '0 || bump_count >= CNT_LIMIT) begin
            o.status = ST_NOPAGE;
         end else begin
            next_addr = longint'(win_start) + longint'(bump_count) * PAGE_BYTES;
            if (next_addr + PAGE_BYTES > longint'(win_end)) begin
               o.status = ST_NOPAGE;
            end else begin
               o.granted_addr = next_addr[ADDR_W-1:0];
               bump_count++;
               granted = 1'b1;
            end
         end
         if (granted) begin
            if (in_use < CNT_LIMIT) in_use++;
            granted_pool.push_back(o.granted_addr);
            if (granted_pool.size() > STACK_DEPTH) void'(granted_pool.pop_front());
         end
      end else begin
         if (r.page_addr == '0) o.status = ST_NULL;
         else if (r.page_addr[PAGE_SHIFT-1:0] != '0) o.status = ST_UNALIGNED;
         else if (r.page_addr < win_start || r.page_addr >= win_end) o.status = ST_RANGE;
         else if (stack_fill >= STACK_DEPTH) o.status = ST_FULL;
         else begin
            freed_stack[stack_fill] = r.page_addr;
            stack_fill++;
            if (in_use > 0) in_use--;
         end
      end
      o.pages_in_use = in_use[CNT_W-1:0];
      o.stack_depth  = stack_fill[DEPTH_W-1:0];
      return o;
   endfunction

   function automatic int draw_gap(bit bursty);
      return bursty ? 0 : int'($urandom_range(0, 10));
   endfunction

   // Free address: mostly pages inside the window, the rest noise
   function automatic logic [ADDR_W-1:0] pick_free_addr();
      int unsigned       roll;
      longint unsigned   lo;
      longint unsigned   span;
      roll = $urandom_range(0, 99);
      if (roll < 6) return '0;
      if (roll < 14) return $urandom();
      if (roll < 20)
         return {(ADDR_W - PAGE_SHIFT)'($urandom_range(0, 32'hFFFFF)), {PAGE_SHIFT{1'b0}}};
      if (roll < 24) return {win_end[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      if (roll < 28) return win_start - PAGE_BYTES;
      if (roll < 55 && granted_pool.size() != 0)
         return granted_pool[$urandom_range(0, granted_pool.size() - 1)];
      lo = (longint'(win_start) + PAGE_BYTES - 1) & ~longint'(PAGE_BYTES - 1);
      if (lo == 0) lo = PAGE_BYTES;
      if (longint'(win_end) <= lo) return $urandom();
      span = (longint'(win_end) - lo + PAGE_BYTES - 1) / PAGE_BYTES;
      return ADDR_W'(lo + longint'($urandom_range(0, int'(span) - 1)) * PAGE_BYTES);
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Register write; the predicted window follows at the handshake
   task automatic csr_write(csr_idx_type idx, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_START) win_start = value;
      else win_end = value;
   endtask

   // Keep the driver queue short so the free pool stays current
   task automatic send_word(func_type f, logic [ADDR_W-1:0] addr);
      req_type w;
      w.func = f;
      w.page_addr = addr;
      while (pending_words.size() >= 4) @(negedge clock);
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
   endtask

   // Driver: one word in flight, held until accepted
   always @(posedge clock) begin : driver
      bit took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) expected_words.push_back(allocator_predict(req_data));
         if (!req_valid || took) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (drain_hold && expected_words.size() != 0) begin
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_data   <= pending_words.pop_front();
               req_valid  <= 1'b1;
               send_gap   = draw_gap(sender_bursty);
               drain_hold = ($urandom_range(0, 39) == 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word, then draw the next stall
   always @(posedge clock) begin : receiver
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with none expected, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = expected_words.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("granted_addr", want.granted_addr, rsp_data.granted_addr);
               check_field("pages_in_use", want.pages_in_use, rsp_data.pages_in_use);
               check_field("stack_depth", want.stack_depth, rsp_data.stack_depth);
            end
            recv_gap = draw_gap(receiver_bursty);
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (recv_gap > 0);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] new_start;
      logic [ADDR_W-1:0] new_end;
      longint unsigned   end_wide;
      int                free_pct;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Window not set up: allocate fails, free checks in order
      send_word(FUNC_ALLOC, 32'hFFFF_FFFF);
      send_word(FUNC_FREE, 32'h0000_0000);
      send_word(FUNC_FREE, 32'hFFFF_FFFF);
      send_word(FUNC_FREE, 32'h0000_1000);
      wait_idle();

      // Three-page window: bump until exhausted, then LIFO reuse
      csr_write(CSR_WINDOW_START, 32'h0001_0000);
      csr_write(CSR_WINDOW_END, 32'h0001_3000);
      repeat (4) send_word(FUNC_ALLOC, $urandom());
      send_word(FUNC_FREE, 32'h0001_1000);
      send_word(FUNC_FREE, 32'h0001_2000);
      repeat (3) send_word(FUNC_ALLOC, 32'h0000_0000);
      send_word(FUNC_FREE, 32'h0000_F000);
      send_word(FUNC_FREE, 32'h0001_3000);
      send_word(FUNC_FREE, 32'h0001_0800);
      send_word(FUNC_FREE, 32'h0001_0000);
      wait_idle();

      // Zero start: frees below the end accepted, stack still pops
      csr_write(CSR_WINDOW_START, 32'h0000_0000);
      csr_write(CSR_WINDOW_END, 32'h0002_0000);
      send_word(FUNC_FREE, 32'h0000_5000);
      repeat (3) send_word(FUNC_ALLOC, $urandom());
      wait_idle();

      // Top of the address space
      csr_write(CSR_WINDOW_START, 32'hFFFF_F000);
      csr_write(CSR_WINDOW_END, 32'hFFFF_FFFF);
      send_word(FUNC_ALLOC, $urandom());
      send_word(FUNC_FREE, 32'hFFFF_F000);
      send_word(FUNC_ALLOC, $urandom());
      send_word(FUNC_FREE, 32'h8000_0000);

      // Random phases, each under its own window setting
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         case (p % 4)
            0: begin
               new_start = '0;
               new_end   = $urandom() | 32'h8000_0000;
            end
            1: begin
               new_start = {(ADDR_W - PAGE_SHIFT)'($urandom_range(1, 32'h3FFFF)),
                            {PAGE_SHIFT{1'b0}}};
               end_wide  = longint'(new_start)
                         + longint'(bump_count + $urandom_range(0, 40)) * PAGE_BYTES;
               new_end   = (end_wide > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : end_wide[31:0];
            end
            2: begin
               new_start = {(ADDR_W - PAGE_SHIFT)'($urandom_range(1, 32'hFFFF)),
                            {PAGE_SHIFT{1'b0}}};
               new_end   = 32'hFFFF_FFFF;
            end
            default: begin
               new_start = $urandom();
               new_end   = $urandom();
            end
         endcase
         csr_write(CSR_WINDOW_START, new_start);
         csr_write(CSR_WINDOW_END, new_end);
         free_pct = (p < 2 || p == 5) ? 93 : (p == 3 || p == 6) ? 50 : 25;
         sender_bursty   = ($urandom_range(0, 3) == 0);
         receiver_bursty = ($urandom_range(0, 3) == 0);
         // Hold the result side off while words keep coming
         if (p == 2) begin
            @(negedge clock);
            sender_bursty = 1'b1;
            long_hold_req = 1'b1;
         end
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(0, 99) < free_pct) send_word(FUNC_FREE, pick_free_addr());
            else send_word(FUNC_ALLOC, $urandom());
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_front.sv
hw/rtl/pfa_fifo.sv
hw/rtl/pfa_back.sv
hw/rtl/page_frame_allocator.sv
tb/page_frame_allocator_test.sv
